FILE: rtl/core/morse_keying_sequencer_top_assert.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef MORSE_KEYING_SEQUENCER_TOP_ASSERT_SVH
`define MORSE_KEYING_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define MKS_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mks assertion failed");

// next-cycle implication
`define MKS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mks assertion failed");

`endif

FILE: rtl/core/mks_pkg.sv
package mks_pkg;

  localparam int unsigned SymBitsW  = 8;
  localparam int unsigned SymCountW = 4;
  localparam int unsigned DurW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned OpW       = 2;

  localparam logic [DurW-1:0] DitReset     = 16'd1;
  localparam logic [DurW-1:0] DahReset     = 16'd3;
  localparam logic [DurW-1:0] GapSymReset  = 16'd1;
  localparam logic [DurW-1:0] GapCharReset = 16'd3;
  localparam logic [DurW-1:0] GapWordReset = 16'd7;

  typedef enum logic [OpW-1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_WORD = 2'd2,
    OP_STOP = 2'd3
  } mks_op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SYMBOL  = 2'd1,
    PH_SYMGAP  = 2'd2,
    PH_CHARGAP = 2'd3
  } mks_phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIT      = 3'd0,
    CFG_DAH      = 3'd1,
    CFG_GAP_SYM  = 3'd2,
    CFG_GAP_CHAR = 3'd3,
    CFG_GAP_WORD = 3'd4
  } mks_cfg_idx_e;

  typedef struct packed {
    logic [DurW-1:0] dit;
    logic [DurW-1:0] dah;
    logic [DurW-1:0] gap_sym;
    logic [DurW-1:0] gap_char;
    logic [DurW-1:0] gap_word;
  } mks_cfg_t;

  typedef struct packed {
    mks_op_e              opcode;
    logic [SymBitsW-1:0]  symbol_bits;
    logic [SymCountW-1:0] sym_cnt;
  } mks_item_t;

  typedef struct packed {
    logic busy_res;
    logic status;
    logic key_level;
  } mks_res_t;

endpackage

FILE: rtl/core/mks_cfg.sv
module mks_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mks_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mks_pkg::DurW-1:0]    cfg_data_i,
  output mks_pkg::mks_cfg_t           cfg_o
);

  mks_pkg::mks_cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mks_pkg::CFG_DIT:      cfg_d.dit      = cfg_data_i;
        mks_pkg::CFG_DAH:      cfg_d.dah      = cfg_data_i;
        mks_pkg::CFG_GAP_SYM:  cfg_d.gap_sym  = cfg_data_i;
        mks_pkg::CFG_GAP_CHAR: cfg_d.gap_char = cfg_data_i;
        mks_pkg::CFG_GAP_WORD: cfg_d.gap_word = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit      <= mks_pkg::DitReset;
      cfg_q.dah      <= mks_pkg::DahReset;
      cfg_q.gap_sym  <= mks_pkg::GapSymReset;
      cfg_q.gap_char <= mks_pkg::GapCharReset;
      cfg_q.gap_word <= mks_pkg::GapWordReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/mks_in_reg.sv
module mks_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mks_pkg::mks_item_t  in_item_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output mks_pkg::mks_item_t  item_o
);

  logic               vld_d, vld_q;
  mks_pkg::mks_item_t item_q;

  assign in_ready_o = !vld_q || item_take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/core/mks_core.sv
module mks_core #(
  parameter int unsigned MAX_SYMBOLS = 8,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  mks_pkg::mks_item_t item_i,
  output logic               item_take_o,
  input  mks_pkg::mks_cfg_t  cfg_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output mks_pkg::mks_res_t  res_o
);

  localparam int unsigned CntW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned SelW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [TICK_WIDTH-1:0] TickMax = '1;
  localparam logic [mks_pkg::SymCountW:0] MaxCnt = (mks_pkg::SymCountW + 1)'(MAX_SYMBOLS);

  mks_pkg::mks_phase_e     phase_d, phase_q;
  logic [MAX_SYMBOLS-1:0]  store_d, store_q;
  logic                    store_we;
  logic [CntW-1:0]         loaded_d, loaded_q;
  logic [CntW-1:0]         idx_d, idx_q;
  logic [CntW-1:0]         idx_inc;
  logic [CntW-1:0]         cnt_sat;
  logic [TICK_WIDTH-1:0]   elapsed_d, elapsed_q;
  logic [TICK_WIDTH-1:0]   elapsed_inc;
  logic [TICK_WIDTH-1:0]   target_d, target_q;
  logic                    busy_d, busy_q;
  logic                    cur_dah;
  logic [MAX_SYMBOLS+mks_pkg::SymBitsW-1:0] bits_ext;
  mks_pkg::mks_res_t       res_d, res_q;
  logic                    res_vld_d, res_vld_q;

  function automatic logic [TICK_WIDTH-1:0] clamp_dur(input logic [mks_pkg::DurW-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(TickMax)) begin
      return TickMax;
    end
    return TICK_WIDTH'(v);
  endfunction

  assign item_take_o = item_valid_i && (!res_vld_q || res_ready_i);

  assign bits_ext    = {{MAX_SYMBOLS{1'b0}}, item_i.symbol_bits};
  assign elapsed_inc = elapsed_q + TICK_WIDTH'(1);
  assign idx_inc     = idx_q + CntW'(1);
  assign cur_dah     = (32'(idx_q) < 32'(MAX_SYMBOLS)) ? store_q[idx_q[SelW-1:0]] : 1'b0;
  assign cnt_sat     = ({1'b0, item_i.sym_cnt} > MaxCnt) ? CntW'(MAX_SYMBOLS)
                                                        : CntW'(item_i.sym_cnt);

  always_comb begin
    phase_d   = phase_q;
    store_d   = bits_ext[MAX_SYMBOLS-1:0];
    store_we  = 1'b0;
    loaded_d  = loaded_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    busy_d    = busy_q;
    res_d     = '0;
    if (item_take_o) begin
      case (item_i.opcode)
        mks_pkg::OP_TICK: begin
          if (phase_q != mks_pkg::PH_IDLE) begin
            res_d.key_level = (phase_q == mks_pkg::PH_SYMBOL);
            if (elapsed_inc < target_q) begin
              elapsed_d = elapsed_inc;
            end else begin
              elapsed_d = '0;
              case (phase_q)
                mks_pkg::PH_SYMBOL: begin
                  idx_d = idx_inc;
                  if (idx_inc < loaded_q) begin
                    phase_d  = mks_pkg::PH_SYMGAP;
                    target_d = clamp_dur(cfg_i.gap_sym);
                  end else begin
                    phase_d  = mks_pkg::PH_CHARGAP;
                    target_d = clamp_dur(cfg_i.gap_char);
                  end
                end
                mks_pkg::PH_SYMGAP: begin
                  phase_d  = mks_pkg::PH_SYMBOL;
                  target_d = clamp_dur(cur_dah ? cfg_i.dah : cfg_i.dit);
                end
                default: begin
                  phase_d = mks_pkg::PH_IDLE;
                  busy_d  = 1'b0;
                end
              endcase
            end
          end
        end
        mks_pkg::OP_LOAD: begin
          if (busy_q) begin
            res_d.status = 1'b1;
          end else begin
            store_we  = 1'b1;
            loaded_d  = cnt_sat;
            idx_d     = '0;
            elapsed_d = '0;
            if (cnt_sat != '0) begin
              busy_d   = 1'b1;
              phase_d  = mks_pkg::PH_SYMBOL;
              target_d = clamp_dur(bits_ext[0] ? cfg_i.dah : cfg_i.dit);
            end
          end
        end
        mks_pkg::OP_WORD: begin
          if (busy_q) begin
            res_d.status = 1'b1;
          end else begin
            loaded_d  = '0;
            idx_d     = '0;
            elapsed_d = '0;
            target_d  = clamp_dur(cfg_i.gap_word);
            phase_d   = mks_pkg::PH_CHARGAP;
            busy_d    = 1'b1;
          end
        end
        default: begin
          phase_d   = mks_pkg::PH_IDLE;
          busy_d    = 1'b0;
          elapsed_d = '0;
          loaded_d  = '0;
        end
      endcase
      res_d.busy_res = busy_d;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (item_take_o) begin
      res_vld_d = 1'b1;
    end else if (res_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mks_pkg::PH_IDLE;
      loaded_q  <= '0;
      idx_q     <= '0;
      elapsed_q <= '0;
      target_q  <= '0;
      busy_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      loaded_q  <= loaded_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
      target_q  <= target_d;
      busy_q    <= busy_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q <= store_d;
    end
    if (item_take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

`include "morse_keying_sequencer_top_assert.svh"

  `MKS_ASSERT_IMPL(a_busy_phase, 1'b1, busy_q == (phase_q != mks_pkg::PH_IDLE))
  `MKS_ASSERT_IMPL(a_idx_in_char,
                   phase_q == mks_pkg::PH_SYMBOL || phase_q == mks_pkg::PH_SYMGAP,
                   idx_q < loaded_q)
  `MKS_ASSERT_NEXT(a_load_starts,
                   item_take_o && item_i.opcode == mks_pkg::OP_LOAD && !busy_q &&
                   item_i.sym_cnt != '0,
                   phase_q == mks_pkg::PH_SYMBOL && idx_q == '0 && elapsed_q == '0)
  `MKS_ASSERT_NEXT(a_stop_idles,
                   item_take_o && item_i.opcode == mks_pkg::OP_STOP,
                   phase_q == mks_pkg::PH_IDLE && !busy_q && elapsed_q == '0)

endmodule

FILE: rtl/core/morse_keying_sequencer_top.sv
// channel   dir  handshake                         payload
// s_axis    in   s_axis_tvalid / s_axis_tready     tuser opcode, tdata symbols and count
// m_axis    out  m_axis_tvalid / m_axis_tready     tdata key level, status, busy
// cfg       in   cfg_valid_i / cfg_ready_o         cfg_index_i, cfg_data_i
//
// one beat per clock sustained while m_axis_tready stays high; each input beat passes
// through the input register, then the state update into the result register
// while a result waits on m_axis_tready the input register takes one more beat,
// then s_axis_tready stays low until the result is taken
// rst_ni clears the sequencer to idle and loads the default durations
// cfg_ready_o is always high; write only while no beat is in flight
module morse_keying_sequencer_top #(
  parameter int unsigned MAX_SYMBOLS = 8,
  parameter int unsigned TICK_WIDTH  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // symbol_bits[7:0], sym_cnt[11:8]
  input  logic [1:0]                  s_axis_tuser,   // opcode[1:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // key_level[0], status[1], busy_res[2]
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mks_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mks_pkg::DurW-1:0]    cfg_data_i
);

  mks_pkg::mks_item_t in_item;
  mks_pkg::mks_item_t item;
  mks_pkg::mks_cfg_t  cfg;
  mks_pkg::mks_res_t  res;
  logic               item_valid;
  logic               item_take;

  assign in_item.opcode      = mks_pkg::mks_op_e'(s_axis_tuser);
  assign in_item.symbol_bits = s_axis_tdata[7:0];
  assign in_item.sym_cnt     = s_axis_tdata[11:8];

  mks_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mks_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  mks_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .TICK_WIDTH  (TICK_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .cfg_i        (cfg),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {5'b0, res.busy_res, res.status, res.key_level};

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned ClkHalf = 5;
  localparam int unsigned SymMax  = 8;
  localparam int unsigned MaxShow = 10;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;
  logic [1:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b1;
  logic [7:0]                    m_axis_tdata;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [mks_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [mks_pkg::DurW-1:0]      cfg_data_i;

  morse_keying_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // keyer shadow state
  mks_pkg::mks_cfg_t             dur_cfg;
  mks_pkg::mks_phase_e           key_phase;
  logic [SymMax-1:0]             sym_store;
  logic [mks_pkg::SymCountW-1:0] sym_loaded;
  logic [mks_pkg::SymCountW-1:0] sym_pos;
  logic [mks_pkg::DurW-1:0]      tick_count;
  logic [mks_pkg::DurW-1:0]      phase_len;
  logic                          seq_busy;

  mks_pkg::mks_res_t key_res_q[$];
  mks_pkg::mks_res_t exp_r;
  mks_pkg::mks_res_t got_r;
  int unsigned       err_count;
  int unsigned       beats_sent;
  int unsigned       beats_checked;
  int unsigned       loads_ok;
  int unsigned       rejects;
  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic void reset_keyer();
    dur_cfg.dit      = mks_pkg::DitReset;
    dur_cfg.dah      = mks_pkg::DahReset;
    dur_cfg.gap_sym  = mks_pkg::GapSymReset;
    dur_cfg.gap_char = mks_pkg::GapCharReset;
    dur_cfg.gap_word = mks_pkg::GapWordReset;
    key_phase  = mks_pkg::PH_IDLE;
    sym_store  = '0;
    sym_loaded = '0;
    sym_pos    = '0;
    tick_count = '0;
    phase_len  = '0;
    seq_busy   = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [mks_pkg::CfgIdxW-1:0] idx,
                                    input logic [mks_pkg::DurW-1:0] val);
    case (mks_pkg::mks_cfg_idx_e'(idx))
      mks_pkg::CFG_DIT:      dur_cfg.dit      = val;
      mks_pkg::CFG_DAH:      dur_cfg.dah      = val;
      mks_pkg::CFG_GAP_SYM:  dur_cfg.gap_sym  = val;
      mks_pkg::CFG_GAP_CHAR: dur_cfg.gap_char = val;
      mks_pkg::CFG_GAP_WORD: dur_cfg.gap_word = val;
      default: ;
    endcase
  endfunction

  function automatic void begin_symbol();
    logic dah;
    dah = (sym_pos < SymMax) ? sym_store[sym_pos[2:0]] : 1'b0;
    key_phase = mks_pkg::PH_SYMBOL;
    phase_len = dah ? dur_cfg.dah : dur_cfg.dit;
  endfunction

  function automatic logic advance_tick();
    logic lvl;
    if (key_phase == mks_pkg::PH_IDLE) return 1'b0;
    lvl = (key_phase == mks_pkg::PH_SYMBOL);
    tick_count = tick_count + 1'b1;
    if (tick_count < phase_len) return lvl;
    tick_count = '0;
    case (key_phase)
      mks_pkg::PH_SYMBOL: begin
        sym_pos = sym_pos + 1'b1;
        if (sym_pos < sym_loaded) begin
          key_phase = mks_pkg::PH_SYMGAP;
          phase_len = dur_cfg.gap_sym;
        end else begin
          key_phase = mks_pkg::PH_CHARGAP;
          phase_len = dur_cfg.gap_char;
        end
      end
      mks_pkg::PH_SYMGAP: begin_symbol();
      default: begin
        key_phase = mks_pkg::PH_IDLE;
        seq_busy  = 1'b0;
      end
    endcase
    return lvl;
  endfunction

  function automatic mks_pkg::mks_res_t predict_key(input mks_pkg::mks_op_e op,
                                                    input logic [mks_pkg::SymBitsW-1:0] bits,
                                                    input logic [mks_pkg::SymCountW-1:0] cnt);
    mks_pkg::mks_res_t             r;
    logic [mks_pkg::SymCountW-1:0] n;
    r = '0;
    case (op)
      mks_pkg::OP_TICK: r.key_level = advance_tick();
      mks_pkg::OP_LOAD: begin
        if (seq_busy) begin
          r.status = 1'b1;
        end else begin
          n = (cnt > SymMax) ? mks_pkg::SymCountW'(SymMax) : cnt;
          for (int i = 0; i < SymMax; i++)
            if (i < n) sym_store[i] = bits[i];
          sym_loaded = n;
          sym_pos    = '0;
          tick_count = '0;
          if (n != 0) begin
            seq_busy = 1'b1;
            begin_symbol();
            loads_ok++;
          end
        end
      end
      mks_pkg::OP_WORD: begin
        if (seq_busy) begin
          r.status = 1'b1;
        end else begin
          sym_loaded = '0;
          sym_pos    = '0;
          tick_count = '0;
          phase_len  = dur_cfg.gap_word;
          key_phase  = mks_pkg::PH_CHARGAP;
          seq_busy   = 1'b1;
        end
      end
      default: begin
        key_phase  = mks_pkg::PH_IDLE;
        seq_busy   = 1'b0;
        tick_count = '0;
        sym_loaded = '0;
      end
    endcase
    if (r.status) rejects++;
    r.busy_res = seq_busy;
    return r;
  endfunction

  task automatic send_item(input mks_pkg::mks_op_e op,
                           input logic [mks_pkg::SymBitsW-1:0] bits,
                           input logic [mks_pkg::SymCountW-1:0] cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, cnt, bits};
    do @(posedge clk_i); while (!s_axis_tready);
    key_res_q.push_back(predict_key(op, bits, cnt));
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (key_res_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mks_pkg::CfgIdxW-1:0] idx,
                           input logic [mks_pkg::DurW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_durations(input logic [mks_pkg::DurW-1:0] dit,
                               input logic [mks_pkg::DurW-1:0] dah,
                               input logic [mks_pkg::DurW-1:0] gsym,
                               input logic [mks_pkg::DurW-1:0] gchar,
                               input logic [mks_pkg::DurW-1:0] gword);
    wait_drained();
    write_reg(mks_pkg::CFG_DIT, dit);
    write_reg(mks_pkg::CFG_DAH, dah);
    write_reg(mks_pkg::CFG_GAP_SYM, gsym);
    write_reg(mks_pkg::CFG_GAP_CHAR, gchar);
    write_reg(mks_pkg::CFG_GAP_WORD, gword);
  endtask

  task automatic play_out();
    while (seq_busy)
      send_item(mks_pkg::OP_TICK, mks_pkg::SymBitsW'($urandom),
                mks_pkg::SymCountW'($urandom));
  endtask

  function automatic logic [mks_pkg::DurW-1:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return mks_pkg::DurW'(1);
    if (roll < 25) return mks_pkg::DurW'($urandom_range(7, 40));
    return mks_pkg::DurW'($urandom_range(1, 6));
  endfunction

  task automatic test_commands();
    send_item(mks_pkg::OP_TICK, '0, '0);
    send_item(mks_pkg::OP_STOP, 8'hFF, 4'hF);
    send_item(mks_pkg::OP_LOAD, 8'hFF, 4'd0);
    send_item(mks_pkg::OP_WORD, '0, '0);
    send_item(mks_pkg::OP_WORD, 8'hFF, 4'hF);
    send_item(mks_pkg::OP_LOAD, 8'h55, 4'd3);
    play_out();
    send_item(mks_pkg::OP_LOAD, 8'b0000_0010, 4'd2);
    play_out();
    send_item(mks_pkg::OP_LOAD, 8'h80, 4'd8);
    send_item(mks_pkg::OP_TICK, '0, '0);
    send_item(mks_pkg::OP_STOP, '0, '0);
    send_item(mks_pkg::OP_TICK, '0, '0);
  endtask

  task automatic test_zero_durations();
    set_durations('0, '0, '0, '0, '0);
    send_item(mks_pkg::OP_LOAD, 8'hFF, 4'hF);
    play_out();
    send_item(mks_pkg::OP_WORD, '0, '0);
    play_out();
  endtask

  task automatic test_unused_regs();
    wait_drained();
    for (int i = int'(mks_pkg::CFG_GAP_WORD) + 1; i < (1 << mks_pkg::CfgIdxW); i++)
      write_reg(mks_pkg::CfgIdxW'(i), mks_pkg::DurW'($urandom));
    send_item(mks_pkg::OP_LOAD, 8'hA5, 4'd8);
    play_out();
  endtask

  task automatic test_long_durations();
    set_durations('1, '1, '1, '1, '1);
    send_item(mks_pkg::OP_LOAD, 8'h01, 4'd1);
    repeat (20) send_item(mks_pkg::OP_TICK, '0, '0);
    send_item(mks_pkg::OP_STOP, '0, '0);
    send_item(mks_pkg::OP_WORD, '0, '0);
    repeat (20) send_item(mks_pkg::OP_TICK, '0, '0);
    send_item(mks_pkg::OP_STOP, '0, '0);
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned n_items);
    int unsigned                   roll;
    logic [mks_pkg::SymCountW-1:0] cnt;
    logic [mks_pkg::SymBitsW-1:0]  bits;
    set_durations(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                  pick_duration());
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n_items) begin
      roll = $urandom_range(99);
      bits = mks_pkg::SymBitsW'($urandom);
      cnt  = ($urandom_range(9) == 0) ? mks_pkg::SymCountW'($urandom_range(15))
                                      : mks_pkg::SymCountW'($urandom_range(1, SymMax));
      if (roll < 2) wait_drained();
      if (!seq_busy) begin
        if (roll < 60) send_item(mks_pkg::OP_LOAD, bits, cnt);
        else if (roll < 80) send_item(mks_pkg::OP_WORD, bits, cnt);
        else if (roll < 90) send_item(mks_pkg::OP_STOP, bits, cnt);
        else send_item(mks_pkg::OP_TICK, bits, cnt);
      end else begin
        if (roll < 85) send_item(mks_pkg::OP_TICK, bits, cnt);
        else if (roll < 91) send_item(mks_pkg::OP_LOAD, bits, cnt);
        else if (roll < 96) send_item(mks_pkg::OP_WORD, bits, cnt);
        else send_item(mks_pkg::OP_STOP, bits, cnt);
      end
    end
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata[2:0];
      if (key_res_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxShow) $display("unexpected result beat %b", m_axis_tdata);
      end else begin
        exp_r = key_res_q.pop_front();
        beats_checked++;
        if (got_r.key_level !== exp_r.key_level || got_r.status !== exp_r.status ||
            got_r.busy_res !== exp_r.busy_res) begin
          err_count++;
          if (err_count <= MaxShow)
            $display("result %0d: exp key %b status %b busy %b, got key %b status %b busy %b",
                     beats_checked, exp_r.key_level, exp_r.status, exp_r.busy_res,
                     got_r.key_level, got_r.status, got_r.busy_res);
        end
      end
    end
  end

  initial begin
    #(64'd30_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = mks_pkg::OP_TICK;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = mks_pkg::CFG_DIT;
    cfg_data_i     = '0;
    err_count      = 0;
    beats_sent     = 0;
    beats_checked  = 0;
    loads_ok       = 0;
    rejects        = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    reset_keyer();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_zero_durations();
    test_unused_regs();
    test_long_durations();
    test_random(0, 0, 86);
    test_random(46, 0, 86);
    test_random(0, 46, 86);
    test_random(13, 13, 86);
    wait_drained();

    $display("sent %0d beats, checked %0d results, %0d loads started, %0d commands rejected",
             beats_sent, beats_checked, loads_ok, rejects);
    $display("durations from zero to full scale, idle mixes none, source, sink and both");
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
